>>> rtl/gic_pkg.sv
// gic_pkg: shared types, sizes and codes for the geofence intrusion check
// used by every module of the block but gic_ram; depends on nothing
package gic_pkg;

  localparam int CW        = 24;              // coordinate bits
  localparam int DW        = CW + 1;          // coordinate difference bits
  localparam int PW        = 2 * DW;          // edge product bits
  localparam int MAX_V     = 16;              // vertex store depth
  localparam int MAX_S     = 8;               // stub store depth
  localparam int VA_W      = $clog2(MAX_V);
  localparam int SA_W      = $clog2(MAX_S);
  localparam int CNT_W     = $clog2(MAX_V + 1);
  localparam int IDX_W     = 4;
  localparam int CC_W      = 5;
  localparam int VC_W      = 5;
  localparam int ADW       = 16;              // alarm distance bits
  localparam int LIM_W     = 2 * ADW;
  localparam int SQ_W      = 2 * ADW + 1;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int DRAIN_CYC = 4;
  localparam int QD        = 2;
  localparam int QA_W      = 1;
  localparam int QC_W      = 2;

  localparam logic [1:0] OP_VWR = 2'd0;
  localparam logic [1:0] OP_SWR = 2'd1;
  localparam logic [1:0] OP_QRY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_AD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VC = 2'd2;

  localparam logic [VC_W-1:0] VC_RESET = 5'd2;

  typedef enum logic [1:0] {K_NOP, K_VWR, K_SWR, K_QRY} kind_t;
  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN} state_t;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [IDX_W-1:0]       entry_index;
    logic                   entry_valid;
    logic signed [CW-1:0]   coord_x;
    logic signed [CW-1:0]   coord_y;
  } in_word_t;

  typedef struct packed {
    logic                   invader;
    logic                   near_stub;
    logic                   in_polygon;
    logic [CC_W-1:0]        crossing_count;
  } out_word_t;

  typedef struct packed {
    kind_t                  kind;
    logic [IDX_W-1:0]       idx;
    logic                   ok;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
  } entry_t;

endpackage

>>> rtl/geofence_intrusion_check.sv
// geofence_intrusion_check: top level, front queue plus back end executor
// depends on gic_pkg, gic_front, gic_back
// throughput: writes one per cycle while busy is low; a query holds the back end through
// the edge walk, which reads one vertex per cycle, and the drain
// reset: synchronous active low; resets valid bits, queue and config registers; no result held off
module geofence_intrusion_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  gic_pkg::in_word_t             in_word,
  output logic                          out_valid,
  output gic_pkg::out_word_t            out_word,
  input  logic                          cfg_we,
  input  logic [gic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gic_pkg::CFG_W-1:0]     cfg_wdata
);

  logic            q_empty;
  logic            q_pop;
  gic_pkg::entry_t q_head;

  gic_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_word (in_word),
    .busy    (busy),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  gic_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

>>> rtl/gic_ram.sv
// gic_ram: generic single write port, single read port ram
// registered read data; no dependencies
module gic_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/gic_front.sv
// gic_front: accepts words, classifies them and queues them for the back end
// depends on gic_pkg
module gic_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  gic_pkg::in_word_t in_word,
  output logic              busy,
  output logic              q_empty,
  output gic_pkg::entry_t   q_head,
  input  logic              q_pop
);

  gic_pkg::entry_t            q_mem_r [gic_pkg::QD];
  logic [gic_pkg::QA_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [gic_pkg::QC_W-1:0]   cnt_r, cnt_nxt;
  logic                       accept;
  gic_pkg::entry_t            ent;

  // out-of-range writes become no-ops here
  always_comb begin
    ent.idx  = in_word.entry_index;
    ent.ok   = in_word.entry_valid;
    ent.x    = in_word.coord_x;
    ent.y    = in_word.coord_y;
    case (in_word.opcode)
      gic_pkg::OP_VWR:
        ent.kind = (int'(in_word.entry_index) < gic_pkg::MAX_V) ? gic_pkg::K_VWR
                                                                : gic_pkg::K_NOP;
      gic_pkg::OP_SWR:
        ent.kind = (int'(in_word.entry_index) < gic_pkg::MAX_S) ? gic_pkg::K_SWR
                                                                : gic_pkg::K_NOP;
      gic_pkg::OP_QRY: ent.kind = gic_pkg::K_QRY;
      default:         ent.kind = gic_pkg::K_NOP;
    endcase
  end

  assign busy    = (cnt_r == gic_pkg::QC_W'(gic_pkg::QD));
  assign accept  = start && !busy;
  assign q_empty = (cnt_r == '0);
  assign q_head  = q_mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!accept && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem_r[wr_ptr_r] <= ent;
    end
  end

endmodule

>>> rtl/gic_back.sv
// gic_back: executes queued words: store writes, edge walk and stub walk
// depends on gic_pkg and gic_ram
module gic_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  gic_pkg::entry_t               q_head,
  output logic                          q_pop,
  input  logic                          cfg_we,
  input  logic [gic_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gic_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  output gic_pkg::out_word_t            out_word
);

  localparam int CW = gic_pkg::CW;
  localparam int DW = gic_pkg::DW;

  gic_pkg::state_t             state_r, state_nxt;
  logic [gic_pkg::CNT_W-1:0]   cnt_r, cnt_nxt, n_eff;
  gic_pkg::entry_t             cmd_r;
  logic [gic_pkg::ADW-1:0]     ad_r;
  logic                        en_r;
  logic [gic_pkg::VC_W-1:0]    vc_r;
  logic [gic_pkg::LIM_W-1:0]   lim_r;
  logic [gic_pkg::MAX_S-1:0]   sok_r;
  logic                        out_valid_r;
  gic_pkg::out_word_t          out_word_r;
  logic                        fin;

  // vertex walk
  logic                        v_issue, v1_r, vfirst_r;
  logic [gic_pkg::VA_W-1:0]    vraddr;
  logic [2*CW-1:0]             vrdata, prev_r;
  logic signed [DW-1:0]        ax, ay, bx, by, x1, y1, x2, y2, px, py, dxs, d;
  logic                        e1_go;
  logic                        e1_v_r, e1_neg_r, e1_triv_r, e1_tval_r;
  logic [DW-1:0]               e1_a_r, e1_b_r, e1_den_r, e1_m_r;
  logic                        e2_v_r, e2_neg_r, e2_triv_r, e2_tval_r;
  logic [gic_pkg::PW-1:0]      e2_num_r, e2_prod_r;
  logic                        hit;
  logic [gic_pkg::CC_W-1:0]    count_r;

  // stub walk
  logic                        s_issue, s1_r, s2_v_r, near_r;
  logic [2*CW-1:0]             srdata;
  logic signed [DW-1:0]        sdx, sdy;
  logic [DW-1:0]               sdxm, sdym;
  logic [gic_pkg::ADW-1:0]     sa_r, sb_r;
  logic [gic_pkg::SQ_W-1:0]    ssum;

  // ---------------- control ----------------
  assign n_eff = (int'(vc_r) > gic_pkg::MAX_V) ? gic_pkg::CNT_W'(gic_pkg::MAX_V)
                                               : gic_pkg::CNT_W'(vc_r);
  assign fin = (state_r == gic_pkg::S_DRAIN) &&
               (cnt_r == gic_pkg::CNT_W'(gic_pkg::DRAIN_CYC - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    case (state_r)
      gic_pkg::S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_head.kind == gic_pkg::K_QRY) begin
            state_nxt = gic_pkg::S_WALK;
            cnt_nxt   = '0;
          end
        end
      end
      gic_pkg::S_WALK: begin
        if (cnt_r == gic_pkg::CNT_W'(gic_pkg::MAX_V)) begin
          state_nxt = gic_pkg::S_DRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      gic_pkg::S_DRAIN: begin
        if (fin) begin
          state_nxt = gic_pkg::S_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: state_nxt = gic_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gic_pkg::S_IDLE;
      cnt_r       <= '0;
      ad_r        <= '0;
      en_r        <= 1'b0;
      vc_r        <= gic_pkg::VC_RESET;
      sok_r       <= '0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      e1_v_r      <= 1'b0;
      e2_v_r      <= 1'b0;
      s1_r        <= 1'b0;
      s2_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (q_pop && q_head.kind != gic_pkg::K_QRY) || fin;
      v1_r        <= v_issue;
      e1_v_r      <= e1_go;
      e2_v_r      <= e1_v_r;
      s1_r        <= s_issue;
      s2_v_r      <= s1_r && (sdxm[DW-1:gic_pkg::ADW] == '0) &&
                     (sdym[DW-1:gic_pkg::ADW] == '0);
      if (q_pop && q_head.kind == gic_pkg::K_SWR) begin
        sok_r[gic_pkg::SA_W'(q_head.idx)] <= q_head.ok;
      end
      if (cfg_we) begin
        case (cfg_index)
          gic_pkg::CFG_AD: ad_r <= cfg_wdata[gic_pkg::ADW-1:0];
          gic_pkg::CFG_EN: en_r <= cfg_wdata[0];
          gic_pkg::CFG_VC: vc_r <= cfg_wdata[gic_pkg::VC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- stores ----------------
  assign vraddr  = (cnt_r == n_eff) ? '0 : gic_pkg::VA_W'(cnt_r);
  assign v_issue = (state_r == gic_pkg::S_WALK) && (cnt_r <= n_eff) && (n_eff != '0);
  assign s_issue = (state_r == gic_pkg::S_WALK) &&
                   (int'(cnt_r) < gic_pkg::MAX_S) && sok_r[gic_pkg::SA_W'(cnt_r)];

  gic_ram #(.W(2 * CW), .D(gic_pkg::MAX_V)) u_vram (
    .clk   (clk),
    .we    (q_pop && q_head.kind == gic_pkg::K_VWR),
    .waddr (gic_pkg::VA_W'(q_head.idx)),
    .wdata ({q_head.x, q_head.y}),
    .raddr (vraddr),
    .rdata (vrdata)
  );

  gic_ram #(.W(2 * CW), .D(gic_pkg::MAX_S)) u_sram (
    .clk   (clk),
    .we    (q_pop && q_head.kind == gic_pkg::K_SWR),
    .waddr (gic_pkg::SA_W'(q_head.idx)),
    .wdata ({q_head.x, q_head.y}),
    .raddr (gic_pkg::SA_W'(cnt_r)),
    .rdata (srdata)
  );

  // ---------------- edge stage 1: geometry and operands ----------------
  assign px = DW'(cmd_r.x);
  assign py = DW'(cmd_r.y);
  assign ax = DW'($signed(prev_r[2*CW-1:CW]));
  assign ay = DW'($signed(prev_r[CW-1:0]));
  assign bx = DW'($signed(vrdata[2*CW-1:CW]));
  assign by = DW'($signed(vrdata[CW-1:0]));

  always_comb begin
    if (ay < by) begin
      x1 = ax; y1 = ay; x2 = bx; y2 = by;
    end else begin
      x1 = bx; y1 = by; x2 = ax; y2 = ay;
    end
    dxs   = x2 - x1;
    d     = px - x1;
    e1_go = v1_r && !vfirst_r && (ay != by) && (py > y1) && (py <= y2) &&
            (px >= ((ax < bx) ? ax : bx));
  end

  // x1 + q <= px without a divider: compare the product against d * den
  always_ff @(posedge clk) begin
    if (v1_r) begin
      prev_r <= vrdata;
    end
    vfirst_r  <= (cnt_r == '0);
    e1_neg_r  <= dxs[DW-1];
    e1_a_r    <= DW'(py - y1);
    e1_b_r    <= dxs[DW-1] ? DW'(-dxs) : DW'(dxs);
    e1_den_r  <= DW'(y2 - y1);
    if (!dxs[DW-1]) begin
      e1_triv_r <= d[DW-1];
      e1_tval_r <= 1'b0;
      e1_m_r    <= DW'($unsigned(d) + 1'b1);
    end else begin
      e1_triv_r <= !d[DW-1];
      e1_tval_r <= 1'b1;
      e1_m_r    <= DW'(-d);
    end
    // stage 2: products
    e2_neg_r  <= e1_neg_r;
    e2_triv_r <= e1_triv_r;
    e2_tval_r <= e1_tval_r;
    e2_num_r  <= gic_pkg::PW'(e1_a_r) * gic_pkg::PW'(e1_b_r);
    e2_prod_r <= gic_pkg::PW'(e1_den_r) * gic_pkg::PW'(e1_m_r);
  end

  // stage 3: decide and count
  assign hit = e2_v_r && (e2_triv_r ? e2_tval_r
                          : (e2_neg_r ? (e2_num_r >= e2_prod_r) : (e2_num_r < e2_prod_r)));

  // ---------------- stub walk ----------------
  assign sdx  = px - DW'($signed(srdata[2*CW-1:CW]));
  assign sdy  = py - DW'($signed(srdata[CW-1:0]));
  assign sdxm = sdx[DW-1] ? DW'(-sdx) : DW'(sdx);
  assign sdym = sdy[DW-1] ? DW'(-sdy) : DW'(sdy);
  assign ssum = gic_pkg::SQ_W'(gic_pkg::LIM_W'(sa_r) * gic_pkg::LIM_W'(sa_r)) +
                gic_pkg::SQ_W'(gic_pkg::LIM_W'(sb_r) * gic_pkg::LIM_W'(sb_r));

  always_ff @(posedge clk) begin
    sa_r <= sdxm[gic_pkg::ADW-1:0];
    sb_r <= sdym[gic_pkg::ADW-1:0];
    if (q_pop) begin
      cmd_r   <= q_head;
      lim_r   <= gic_pkg::LIM_W'(ad_r) * gic_pkg::LIM_W'(ad_r);
      count_r <= '0;
      near_r  <= 1'b0;
    end else begin
      count_r <= count_r + gic_pkg::CC_W'(hit);
      if (s2_v_r && ssum < gic_pkg::SQ_W'(lim_r)) begin
        near_r <= 1'b1;
      end
    end
  end

  // ---------------- result word ----------------
  always_ff @(posedge clk) begin
    if (fin) begin
      out_word_r.invader        <= en_r && (sok_r[1] || sok_r[2] || sok_r[3]) &&
                                   (near_r || count_r[0]);
      out_word_r.near_stub      <= near_r;
      out_word_r.in_polygon     <= count_r[0];
      out_word_r.crossing_count <= count_r;
    end else if (q_pop) begin
      out_word_r <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/gic_checker.sv
// gic_checker: port level checks on the geofence intrusion check
// depends on gic_pkg; bound to the top level below
module gic_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input gic_pkg::in_word_t             in_word,
  input logic                          out_valid,
  input gic_pkg::out_word_t            out_word,
  input logic                          cfg_we,
  input logic [gic_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [gic_pkg::CFG_W-1:0]     cfg_wdata
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !busy)
    else $error("word or busy seen right after reset");

  a_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.in_polygon == out_word.crossing_count[0])
    else $error("in_polygon does not match crossing parity");

  a_invader_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.invader |-> out_word.near_stub || out_word.in_polygon)
    else $error("invader without near or inside");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_word.crossing_count) <= gic_pkg::MAX_V)
    else $error("crossing count above edge count");

endmodule

bind geofence_intrusion_check gic_checker u_gic_checker (.*);

>>> tb/sv/tb_geofence_intrusion_check.sv
// tb_geofence_intrusion_check: self-checking bench for the geofence intrusion check
// predicts each result word in a small scoreboard class; depends on gic_pkg and the rtl
module tb_geofence_intrusion_check;

  localparam logic [1:0] OP_NONE  = 2'd3;
  localparam int         IDLE_LIM = 4000;
  localparam int         N_PHASE  = 8;
  localparam int         PER_PHASE = 165;
  localparam int         CMAX     = 8388607;

  class geofence_scoreboard;
    longint      vx[gic_pkg::MAX_V], vy[gic_pkg::MAX_V];
    longint      sx[gic_pkg::MAX_S], sy[gic_pkg::MAX_S];
    bit          s_ok[gic_pkg::MAX_S];
    longint      alarm_dist;
    bit          alarm_en;
    int          vcount;
    gic_pkg::out_word_t pending[$];
    int          errors;

    function new();
      foreach (vx[i]) begin vx[i] = 0; vy[i] = 0; end
      foreach (sx[i]) begin sx[i] = 0; sy[i] = 0; s_ok[i] = 0; end
      alarm_dist = 0;
      alarm_en   = 0;
      vcount     = gic_pkg::VC_RESET;
      errors     = 0;
    endfunction

    function void set_reg(logic [gic_pkg::CFG_IDX_W-1:0] idx,
                          logic [gic_pkg::CFG_W-1:0] v);
      case (idx)
        gic_pkg::CFG_AD: alarm_dist = v;
        gic_pkg::CFG_EN: alarm_en = v[0];
        gic_pkg::CFG_VC: vcount = v[gic_pkg::VC_W-1:0];
        default: ;
      endcase
    endfunction

    function bit crosses(longint px, longint py, longint ax, longint ay,
                         longint bx, longint by);
      longint x1, y1, x2, y2, q, mx;
      if (ay == by) return 0;
      if (ay < by) begin x1 = ax; y1 = ay; x2 = bx; y2 = by; end
      else begin x1 = bx; y1 = by; x2 = ax; y2 = ay; end
      if (!(py > y1 && py <= y2)) return 0;
      if (px < ((ax < bx) ? ax : bx)) return 0;
      mx = (x2 < x1) ? x1 - x2 : x2 - x1;
      // truncating division on magnitudes, then restore the sign
      q = ((py - y1) * mx) / (y2 - y1);
      if (x2 < x1) q = -q;
      return (x1 + q) <= px;
    endfunction

    function bit near_stub(longint px, longint py);
      longint dx, dy;
      for (int i = 0; i < gic_pkg::MAX_S; i++) begin
        if (!s_ok[i]) continue;
        dx = px - sx[i]; if (dx < 0) dx = -dx;
        dy = py - sy[i]; if (dy < 0) dy = -dy;
        if (dx > 65535 || dy > 65535) continue;
        if (dx * dx + dy * dy < alarm_dist * alarm_dist) return 1;
      end
      return 0;
    endfunction

    function void note_input(gic_pkg::in_word_t w);
      gic_pkg::out_word_t e;
      longint    px, py;
      int        n, cnt, j;
      bit        nr, ins, gate;
      e  = '0;
      px = longint'($signed(w.coord_x));
      py = longint'($signed(w.coord_y));
      if (w.opcode == gic_pkg::OP_VWR) begin
        if (w.entry_index < gic_pkg::MAX_V) begin
          vx[w.entry_index] = px; vy[w.entry_index] = py;
        end
      end else if (w.opcode == gic_pkg::OP_SWR) begin
        if (w.entry_index < gic_pkg::MAX_S) begin
          sx[w.entry_index] = px; sy[w.entry_index] = py;
          s_ok[w.entry_index] = w.entry_valid;
        end
      end else if (w.opcode == gic_pkg::OP_QRY) begin
        n   = (vcount > gic_pkg::MAX_V) ? gic_pkg::MAX_V : vcount;
        cnt = 0;
        for (int i = 0; i < n; i++) begin
          j = (i + 1 == n) ? 0 : i + 1;
          cnt += crosses(px, py, vx[i], vy[i], vx[j], vy[j]);
        end
        nr   = near_stub(px, py);
        ins  = cnt[0];
        gate = alarm_en && (s_ok[1] || s_ok[2] || s_ok[3]);
        e.invader        = gate && (nr || ins);
        e.near_stub      = nr;
        e.in_polygon     = ins;
        e.crossing_count = (cnt > 31) ? 5'd31 : cnt[gic_pkg::CC_W-1:0];
      end
      pending.push_back(e);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(gic_pkg::out_word_t got);
      gic_pkg::out_word_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word %p", got));
        return;
      end
      e = pending.pop_front();
      if (got.invader !== e.invader)
        report($sformatf("invader got %b exp %b", got.invader, e.invader));
      if (got.near_stub !== e.near_stub)
        report($sformatf("near_stub got %b exp %b", got.near_stub, e.near_stub));
      if (got.in_polygon !== e.in_polygon)
        report($sformatf("in_polygon got %b exp %b", got.in_polygon, e.in_polygon));
      if (got.crossing_count !== e.crossing_count)
        report($sformatf("crossing_count got %0d exp %0d",
                         got.crossing_count, e.crossing_count));
    endtask
  endclass

  logic                          clk = 0;
  logic                          rst_n = 0;
  logic                          start = 0;
  logic                          busy;
  gic_pkg::in_word_t             in_word = '0;
  logic                          out_valid;
  gic_pkg::out_word_t            out_word;
  logic                          cfg_we = 0;
  logic [gic_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gic_pkg::CFG_W-1:0]     cfg_wdata = '0;

  geofence_scoreboard sb = new();
  bit                 v_written[gic_pkg::MAX_V];
  int                 idle_cyc = 0;

  geofence_intrusion_check dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
    .out_valid(out_valid), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // monitor: results first, then the word accepted at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_word);
      if (start && !busy) sb.note_input(in_word);
      if (out_valid || (start && !busy)) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (idle_cyc > IDLE_LIM) begin
        $display("tb_geofence_intrusion_check: done, errors");
        $finish;
      end
    end
  end

  function automatic int pick_gap(bit busy_phase);
    int r;
    if (!busy_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [gic_pkg::CW-1:0] rand_coord(int span);
    if (span >= CMAX) return gic_pkg::CW'($urandom());
    return gic_pkg::CW'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic gic_pkg::in_word_t mk(logic [1:0] op, int idx, bit ok, int x, int y);
    gic_pkg::in_word_t w;
    w.opcode = op; w.entry_index = gic_pkg::IDX_W'(idx); w.entry_valid = ok;
    w.coord_x = gic_pkg::CW'(x); w.coord_y = gic_pkg::CW'(y);
    return w;
  endfunction

  task automatic send_word(gic_pkg::in_word_t w, int gap);
    start   <= 1;
    in_word <= w;
    if (w.opcode == gic_pkg::OP_VWR) v_written[w.entry_index] = 1;
    @(posedge clk iff (start && !busy));
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (gic_pkg::DRAIN_CYC + 2) @(posedge clk);
  endtask

  task automatic write_reg(logic [gic_pkg::CFG_IDX_W-1:0] idx,
                           logic [gic_pkg::CFG_W-1:0] v);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic run_phase(int ad, bit en, int vc, int span);
    gic_pkg::in_word_t w;
    int       r, n_done, lim, k;
    bit       gappy;
    write_reg(gic_pkg::CFG_AD, gic_pkg::CFG_W'(ad));
    write_reg(gic_pkg::CFG_EN, {15'($urandom_range(0, 32767)), en});
    write_reg(gic_pkg::CFG_VC, gic_pkg::CFG_W'(vc));
    lim = (vc > gic_pkg::MAX_V) ? gic_pkg::MAX_V : vc;
    // vertices below the count must hold data before any query reads them
    for (int i = 0; i < lim; i++)
      if (!v_written[i])
        send_word(mk(gic_pkg::OP_VWR, i, 0, rand_coord(span), rand_coord(span)), 0);
    n_done = 0;
    gappy  = 1;
    while (n_done < PER_PHASE) begin
      if ($urandom_range(0, 39) == 0) gappy = !gappy;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        w = mk(gic_pkg::OP_QRY, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
               rand_coord(span), rand_coord(span));
        if ($urandom_range(0, 3) == 0 && lim > 0) begin
          // land on a vertex height to hit the edge end rules
          k = $urandom_range(0, lim - 1);
          w.coord_y = gic_pkg::CW'(sb.vy[k]);
          if ($urandom_range(0, 1)) w.coord_x = gic_pkg::CW'(sb.vx[k]);
        end
        n_done++;
      end else if (r < 78) begin
        k = (lim > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, lim - 1)
                                                    : $urandom_range(0, 15);
        w = mk(gic_pkg::OP_VWR, k, 1'($urandom_range(0, 1)),
               rand_coord(span), rand_coord(span));
        n_done++;
      end else if (r < 95) begin
        k = $urandom_range(0, 15);
        w = mk(gic_pkg::OP_SWR, k, $urandom_range(0, 3) != 0,
               rand_coord(span), rand_coord(span));
        if (k < gic_pkg::MAX_S) n_done++;
      end else begin
        w = mk(OP_NONE, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
               rand_coord(CMAX), rand_coord(CMAX));
      end
      send_word(w, pick_gap(gappy));
      if ($urandom_range(0, 149) == 0) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    int ad_tab[N_PHASE]   = '{0, 65535, 1500, 300, 65535, 800, 40000, 2500};
    bit en_tab[N_PHASE]   = '{1, 1, 1, 0, 1, 1, 1, 1};
    int vc_tab[N_PHASE]   = '{16, 5, 0, 4, 31, 1, 17, 2};
    int span_tab[N_PHASE] = '{3000, 2000, 3000, 2500, 8388607, 4000, 3000, 1500};
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: square of side 2000 about the origin, a stub beside it, boundary and extreme points
    write_reg(gic_pkg::CFG_AD, 16'd500);
    write_reg(gic_pkg::CFG_EN, 16'd1);
    write_reg(gic_pkg::CFG_VC, 16'd4);
    send_word(mk(gic_pkg::OP_VWR, 0, 0, -1000, -1000), 0);
    send_word(mk(gic_pkg::OP_VWR, 1, 0, 1000, -1000), 0);
    send_word(mk(gic_pkg::OP_VWR, 2, 1, 1000, 1000), 1);
    send_word(mk(gic_pkg::OP_VWR, 3, 0, -1000, 1000), 0);
    send_word(mk(gic_pkg::OP_SWR, 2, 1, 3000, 0), 0);
    send_word(mk(gic_pkg::OP_SWR, 9, 1, 0, 0), 0);
    send_word(mk(gic_pkg::OP_VWR, 15, 0, CMAX, CMAX), 0);
    send_word(mk(gic_pkg::OP_QRY, 0, 0, 0, 0), 0);
    send_word(mk(gic_pkg::OP_QRY, 0, 0, 2000, 0), 2);
    send_word(mk(gic_pkg::OP_QRY, 0, 0, 3100, 0), 0);
    send_word(mk(gic_pkg::OP_QRY, 0, 0, 3499, 0), 0);
    send_word(mk(gic_pkg::OP_QRY, 0, 0, 3500, 0), 0);
    send_word(mk(gic_pkg::OP_QRY, 0, 0, -1000, 1000), 0);
    send_word(mk(gic_pkg::OP_QRY, 0, 0, 0, -1000), 0);
    send_word(mk(gic_pkg::OP_QRY, 0, 0, 1000, 0), 0);
    send_word(mk(gic_pkg::OP_QRY, 15, 1, CMAX, -CMAX - 1), 0);
    send_word(mk(OP_NONE, 15, 1, -1, -1), 0);
    send_word(mk(gic_pkg::OP_SWR, 0, 0, -CMAX - 1, CMAX), 0);
    send_word(mk(gic_pkg::OP_SWR, 7, 1, -1000, 0), 0);
    send_word(mk(gic_pkg::OP_QRY, 0, 0, -1200, 0), 0);
    send_word(mk(gic_pkg::OP_QRY, 0, 0, -CMAX - 1, CMAX), 0);
    wait_idle();

    for (int p = 0; p < N_PHASE; p++)
      run_phase(ad_tab[p], en_tab[p], vc_tab[p], span_tab[p]);

    wait_idle();
    repeat (40) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    if (sb.errors == 0)
      $display("tb_geofence_intrusion_check: done, clean");
    else
      $display("tb_geofence_intrusion_check: done, errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/gic_pkg.sv
rtl/gic_ram.sv
rtl/gic_front.sv
rtl/gic_back.sv
rtl/geofence_intrusion_check.sv
rtl/gic_checker.sv
tb/sv/tb_geofence_intrusion_check.sv
